>>> src/retry_backoff_delay_generator_macros.svh
// assertion macros shared by the rtl files
`ifndef RETRY_BACKOFF_DELAY_GENERATOR_MACROS_SVH
`define RETRY_BACKOFF_DELAY_GENERATOR_MACROS_SVH

// same-cycle implication, checked while out of reset
`define RBDG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define RBDG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rbdg_pkg.sv
package rbdg_pkg;

    localparam int METHOD_W = 2;
    localparam int BASE_W   = 20;
    localparam int DELAY_W  = 22;
    localparam int MULT_W   = 4;
    localparam int EXP_W    = 5;
    localparam int CNT_W    = 8;
    localparam int RND_W    = 32;
    localparam int DIV_W    = DELAY_W + MULT_W;
    localparam int SHIFT_W  = BASE_W + (1 << EXP_W) - 1;
    localparam int STEP_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DELAY_W;
    localparam int OUT_TDATA_W = ((DELAY_W + 7) / 8) * 8;

    localparam logic [METHOD_W-1:0] METH_CONST  = 2'd0;
    localparam logic [METHOD_W-1:0] METH_EXP    = 2'd1;
    localparam logic [METHOD_W-1:0] METH_JITTER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP  = 3'd5;

    localparam logic [METHOD_W-1:0] RST_METHOD  = METH_CONST;
    localparam logic [BASE_W-1:0]   RST_BASE    = 20'd1000;
    localparam logic [DELAY_W-1:0]  RST_CAP     = 22'd1800000;
    localparam logic [DELAY_W-1:0]  RST_CONST   = 22'd1000;
    localparam logic [MULT_W-1:0]   RST_MULT    = 4'd3;
    localparam logic [EXP_W-1:0]    RST_MAX_EXP = 5'd21;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;
    localparam logic [STEP_W-1:0] STEP_MAX = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [METHOD_W-1:0] method;
        logic [BASE_W-1:0]   base_ms;
        logic [DELAY_W-1:0]  cap_ms;
        logic [DELAY_W-1:0]  const_ms;
        logic [MULT_W-1:0]   multiplier;
        logic [EXP_W-1:0]    exp_limit;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic req_type;
        logic out_free;
    } t_seq_ctl;

    typedef struct packed {
        logic               ready;
        logic               load_out;
        logic [DELAY_W-1:0] delay_ms;
        logic               error;
    } t_seq_sts;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } t_mod_rsp;

endpackage

>>> src/rbdg_mod_unit.sv
`include "retry_backoff_delay_generator_macros.svh"

module rbdg_mod_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbdg_pkg::t_mod_req                i_req,
    input  logic [rbdg_pkg::RND_W-1:0]        i_dividend,
    output rbdg_pkg::t_mod_rsp                o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [rbdg_pkg::STEP_W-1:0]   r_step;
    logic [rbdg_pkg::RND_W-1:0]    r_dvd;
    logic [rbdg_pkg::DIV_W-1:0]    r_rem;
    logic [rbdg_pkg::DIV_W-1:0]    r_div;

    logic [rbdg_pkg::DIV_W:0]      w_trial;
    logic                          w_ge;
    logic [rbdg_pkg::DIV_W-1:0]    n_rem;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[rbdg_pkg::RND_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        if (w_ge) begin
            n_rem = rbdg_pkg::DIV_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[rbdg_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[rbdg_pkg::RND_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == rbdg_pkg::STEP_MAX) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    `RBDG_ASSERT_IMPL(a_start_when_idle, i_req.start, !r_busy, "modulo start while busy")
    `RBDG_ASSERT_IMPL(a_divisor_nonzero, i_req.start, i_req.divisor != '0, "zero divisor")
    `RBDG_ASSERT_IMPL(a_rem_below_div, r_busy || r_done, r_rem < r_div, "remainder not reduced")

endmodule

>>> src/rbdg_seq.sv
module rbdg_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbdg_pkg::t_cfg       i_cfg,
    input  rbdg_pkg::t_seq_ctl   i_ctl,
    input  rbdg_pkg::t_mod_rsp   i_mod,
    output rbdg_pkg::t_mod_req   o_mod,
    output rbdg_pkg::t_seq_sts   o_sts
);

    rbdg_pkg::t_state r_state;
    rbdg_pkg::t_state n_state;

    logic [rbdg_pkg::CNT_W-1:0]   r_count;
    logic [rbdg_pkg::DELAY_W-1:0] r_last_delay;
    logic                         r_err;
    logic                         r_req;
    logic                         r_use_cap;
    logic [rbdg_pkg::DIV_W-1:0]   r_add;

    logic [rbdg_pkg::EXP_W-1:0]   w_exp;
    logic [rbdg_pkg::SHIFT_W-1:0] w_shifted;
    logic [rbdg_pkg::DELAY_W-1:0] w_t;
    logic [rbdg_pkg::DELAY_W-2:0] w_h;
    logic [rbdg_pkg::DIV_W-1:0]   w_hi;
    logic [rbdg_pkg::DIV_W-1:0]   w_lo;
    logic                         w_hi_le_lo;
    logic [rbdg_pkg::DELAY_W-1:0] w_lo_capped;
    logic                         w_need_div;
    logic [rbdg_pkg::DIV_W-1:0]   w_divisor;
    logic [rbdg_pkg::DIV_W-1:0]   w_sum;
    logic [rbdg_pkg::DELAY_W-1:0] w_fin_delay;

    // exponential and jitter bounds, evaluated in the prep cycle, and the final sum, capped for jitter, used in fin
    always_comb begin
        if (r_count < {{(rbdg_pkg::CNT_W-rbdg_pkg::EXP_W){1'b0}}, i_cfg.exp_limit}) begin
            w_exp = r_count[rbdg_pkg::EXP_W-1:0];
        end else begin
            w_exp = i_cfg.exp_limit;
        end
        w_shifted = {{(rbdg_pkg::SHIFT_W-rbdg_pkg::BASE_W){1'b0}}, i_cfg.base_ms} << w_exp;
        if (w_shifted < {{(rbdg_pkg::SHIFT_W-rbdg_pkg::DELAY_W){1'b0}}, i_cfg.cap_ms}) begin
            w_t = w_shifted[rbdg_pkg::DELAY_W-1:0];
        end else begin
            w_t = i_cfg.cap_ms;
        end
        w_h = w_t[rbdg_pkg::DELAY_W-1:1];

        w_hi = {{(rbdg_pkg::DIV_W-rbdg_pkg::MULT_W){1'b0}}, i_cfg.multiplier}
             * {{(rbdg_pkg::DIV_W-rbdg_pkg::DELAY_W){1'b0}}, r_last_delay};
        w_lo = {{(rbdg_pkg::DIV_W-rbdg_pkg::BASE_W){1'b0}}, i_cfg.base_ms};
        w_hi_le_lo = (w_hi <= w_lo);
        if ({{(rbdg_pkg::DELAY_W-rbdg_pkg::BASE_W){1'b0}}, i_cfg.base_ms} < i_cfg.cap_ms) begin
            w_lo_capped = {{(rbdg_pkg::DELAY_W-rbdg_pkg::BASE_W){1'b0}}, i_cfg.base_ms};
        end else begin
            w_lo_capped = i_cfg.cap_ms;
        end

        w_need_div = 1'b0;
        w_divisor  = '0;
        if (!r_req) begin
            case (i_cfg.method)
                rbdg_pkg::METH_EXP: begin
                    w_need_div = (w_h != '0);
                    w_divisor  = {{(rbdg_pkg::DIV_W-rbdg_pkg::DELAY_W+1){1'b0}}, w_h};
                end
                rbdg_pkg::METH_JITTER: begin
                    w_need_div = !w_hi_le_lo;
                    w_divisor  = w_hi - w_lo;
                end
                default: begin
                    w_need_div = 1'b0;
                end
            endcase
        end

        w_sum = r_add + i_mod.rem;
        if (r_use_cap
            && (w_sum >= {{(rbdg_pkg::DIV_W-rbdg_pkg::DELAY_W){1'b0}}, i_cfg.cap_ms})) begin
            w_fin_delay = i_cfg.cap_ms;
        end else begin
            w_fin_delay = w_sum[rbdg_pkg::DELAY_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbdg_pkg::ST_IDLE: begin
                if (i_ctl.accept) begin
                    n_state = rbdg_pkg::ST_PREP;
                end
            end
            rbdg_pkg::ST_PREP: begin
                if (w_need_div) begin
                    n_state = rbdg_pkg::ST_DIV;
                end else begin
                    n_state = rbdg_pkg::ST_OUT;
                end
            end
            rbdg_pkg::ST_DIV: begin
                if (i_mod.done) begin
                    n_state = rbdg_pkg::ST_FIN;
                end
            end
            rbdg_pkg::ST_FIN: begin
                n_state = rbdg_pkg::ST_OUT;
            end
            rbdg_pkg::ST_OUT: begin
                if (i_ctl.out_free) begin
                    n_state = rbdg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbdg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_sts.ready    = 1'b0;
        o_sts.load_out = 1'b0;
        o_mod.start    = 1'b0;
        case (r_state)
            rbdg_pkg::ST_IDLE: begin
                o_sts.ready = 1'b1;
            end
            rbdg_pkg::ST_PREP: begin
                o_mod.start = w_need_div;
            end
            rbdg_pkg::ST_OUT: begin
                o_sts.load_out = i_ctl.out_free;
            end
            default: begin
                o_sts.ready = 1'b0;
            end
        endcase
    end

    assign o_mod.divisor  = w_divisor;
    assign o_sts.delay_ms = r_last_delay;
    assign o_sts.error    = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rbdg_pkg::ST_IDLE;
            r_count      <= '0;
            r_last_delay <= '0;
            r_err        <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rbdg_pkg::ST_IDLE: begin
                    if (i_ctl.accept) begin
                        r_req <= i_ctl.req_type;
                        r_err <= 1'b0;
                        if (i_ctl.req_type) begin
                            r_count      <= '0;
                            r_last_delay <= '0;
                        end else if (r_count != rbdg_pkg::CNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                rbdg_pkg::ST_PREP: begin
                    if (!r_req) begin
                        case (i_cfg.method)
                            rbdg_pkg::METH_CONST: begin
                                r_last_delay <= i_cfg.const_ms;
                            end
                            rbdg_pkg::METH_EXP: begin
                                r_use_cap <= 1'b0;
                                r_add <= {{(rbdg_pkg::DIV_W-rbdg_pkg::DELAY_W+1){1'b0}}, w_h};
                                if (w_h == '0) begin
                                    r_last_delay <= '0;
                                end
                            end
                            rbdg_pkg::METH_JITTER: begin
                                r_use_cap <= 1'b1;
                                r_add     <= w_lo;
                                if (w_hi_le_lo) begin
                                    r_last_delay <= w_lo_capped;
                                end
                            end
                            default: begin
                                r_err <= 1'b1;
                            end
                        endcase
                    end
                end
                rbdg_pkg::ST_FIN: begin
                    r_last_delay <= w_fin_delay;
                end
                default: begin
                    r_err <= r_err;
                end
            endcase
        end
    end

endmodule

>>> src/retry_backoff_delay_generator.sv
// retry backoff delay generator
// slave stream: one beat per request; tuser is the request kind (0 next attempt,
// 1 reset of delay and attempt count), tdata the 32-bit random word for exponential and jitter.
// master stream: one beat per request; tdata carries the current delay in ms,
// tuser the error flag for an unsupported method.
// configuration: write enable, register index and data; the user must change
// registers only while no request is in flight, which the block does not enforce.
// flow: constant method, unsupported method, reset requests, exponential cases
// with a zero half delay and jitter cases with an empty range pass from idle
// through prep to out. exponential and decorrelated jitter run a bit-serial
// 32-bit modulo, one dividend bit per cycle, in the div state, then fin and out.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next request is taken while it waits.
// when the receiver stalls, the next result holds in the sequencer until the
// output register frees up.
// reset clears the delay, attempt count, all handshakes and loads the default
// register values.
`include "retry_backoff_delay_generator_macros.svh"

module retry_backoff_delay_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rbdg_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [rbdg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [rbdg_pkg::RND_W-1:0]             s_axis_tdata,  // random_word
    input  logic                                   s_axis_tuser,  // req_type
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [rbdg_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // delay_ms, zero pad
    output logic                                   m_axis_tuser   // error
);

    rbdg_pkg::t_cfg     r_cfg;
    rbdg_pkg::t_seq_ctl w_ctl;
    rbdg_pkg::t_seq_sts w_sts;
    rbdg_pkg::t_mod_req w_mod_req;
    rbdg_pkg::t_mod_rsp w_mod_rsp;

    logic [rbdg_pkg::RND_W-1:0]   r_rnd;
    logic                         r_out_valid;
    logic [rbdg_pkg::DELAY_W-1:0] r_out_delay;
    logic                         r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.method     <= rbdg_pkg::RST_METHOD;
            r_cfg.base_ms    <= rbdg_pkg::RST_BASE;
            r_cfg.cap_ms     <= rbdg_pkg::RST_CAP;
            r_cfg.const_ms   <= rbdg_pkg::RST_CONST;
            r_cfg.multiplier <= rbdg_pkg::RST_MULT;
            r_cfg.exp_limit  <= rbdg_pkg::RST_MAX_EXP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbdg_pkg::CFG_METHOD:  r_cfg.method     <= i_cfg_data[rbdg_pkg::METHOD_W-1:0];
                rbdg_pkg::CFG_BASE:    r_cfg.base_ms    <= i_cfg_data[rbdg_pkg::BASE_W-1:0];
                rbdg_pkg::CFG_CAP:     r_cfg.cap_ms     <= i_cfg_data[rbdg_pkg::DELAY_W-1:0];
                rbdg_pkg::CFG_CONST:   r_cfg.const_ms   <= i_cfg_data[rbdg_pkg::DELAY_W-1:0];
                rbdg_pkg::CFG_MULT:    r_cfg.multiplier <= i_cfg_data[rbdg_pkg::MULT_W-1:0];
                rbdg_pkg::CFG_MAX_EXP: r_cfg.exp_limit  <= i_cfg_data[rbdg_pkg::EXP_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign s_axis_tready  = w_sts.ready;
    assign w_ctl.accept   = s_axis_tvalid && w_sts.ready;
    assign w_ctl.req_type = s_axis_tuser;
    assign w_ctl.out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_ctl.accept) begin
            r_rnd <= s_axis_tdata;
        end
    end

    rbdg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (w_ctl),
        .i_mod   (w_mod_rsp),
        .o_mod   (w_mod_req),
        .o_sts   (w_sts)
    );

    rbdg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_mod_req),
        .i_dividend (r_rnd),
        .o_rsp      (w_mod_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.load_out) begin
            r_out_delay <= w_sts.delay_ms;
            r_out_err   <= w_sts.error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(rbdg_pkg::OUT_TDATA_W-rbdg_pkg::DELAY_W){1'b0}}, r_out_delay};
    assign m_axis_tuser  = r_out_err;

    `RBDG_ASSERT_IMPL(a_load_into_free, w_sts.load_out, !r_out_valid || m_axis_tready,
        "output overrun")
    `RBDG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "accept while busy")
    `RBDG_ASSERT_IMPL(a_no_div_when_ready, s_axis_tready, !w_mod_req.start,
        "modulo start while idle")

endmodule
